// ===== hw/rtl/dabb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dabb_pkg;

  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int MAX_HALF_WINDOW_DEF = 4;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [7:0] DIST_HALF1 = 8'd3;
  localparam logic [7:0] DIST_HALF2 = 8'd5;
  localparam logic [7:0] DIST_HALF3 = 8'd7;
  localparam logic [7:0] DIST_KEEP  = 8'd1;

  typedef struct packed {
    logic       operation;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] edge_distance;
  } in_word_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic cfg_write;
    logic bounds;
    logic offset;
    logic start;
    logic issue;
    logic div_init;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic do_emit;
    logic last_rd;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [3:0] half_of(input logic [7:0] d);
    logic [3:0] h;
    if (d <= DIST_KEEP) h = 4'd0;
    else if (d <= DIST_HALF1) h = 4'd1;
    else if (d <= DIST_HALF2) h = 4'd2;
    else if (d <= DIST_HALF3) h = 4'd3;
    else h = 4'd4;
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dabb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dabb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pixel_valid,
  output logic               pixel_stall,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  output dabb_pkg::cmd_t     cmd,
  input  wire dabb_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLS   = 4'd1;
  localparam logic [3:0] S_BND   = 4'd2;
  localparam logic [3:0] S_OFS   = 4'd3;
  localparam logic [3:0] S_ADR   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_HOLD  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd.accept && sts.do_emit) state_next = S_CLS;
      S_CLS:   state_next = S_BND;
      S_BND:   state_next = S_OFS;
      S_OFS:   state_next = S_ADR;
      S_ADR:   state_next = S_SUM;
      S_SUM:   if (sts.last_rd) state_next = S_FLUSH;
      S_FLUSH: state_next = S_DINIT;
      S_DINIT: state_next = S_DIV;
      S_DIV:   if (sts.div_done) state_next = S_HOLD;
      S_HOLD:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign pixel_stall   = (state != S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign cmd.accept    = (state == S_IDLE) && pixel_valid;
  assign cmd.cfg_write = (state == S_IDLE) && cfg_valid;
  assign cmd.bounds    = (state == S_BND);
  assign cmd.offset    = (state == S_OFS);
  assign cmd.start     = (state == S_ADR);
  assign cmd.issue     = (state == S_SUM);
  assign cmd.div_init  = (state == S_DINIT);
  assign cmd.div_step  = (state == S_DIV);
  assign cmd.load      = (state == S_HOLD) && sts.out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/dabb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dabb_datapath #(
  parameter int MAX_WIDTH       = dabb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF_WINDOW = dabb_pkg::MAX_HALF_WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dabb_pkg::cmd_t     cmd,
  output dabb_pkg::sts_t          sts,
  input  wire dabb_pkg::in_word_t pixel,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output dabb_pkg::out_word_t     result
);

  localparam int PIX_DEPTH = (2 * MAX_HALF_WINDOW + 1) * MAX_WIDTH;
  localparam int CLS_DEPTH = (MAX_HALF_WINDOW + 1) * MAX_WIDTH;
  localparam int PA   = $clog2(PIX_DEPTH);
  localparam int CA   = $clog2(CLS_DEPTH);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HB   = $clog2(MAX_HALF_WINDOW + 1);
  localparam int SPAN = 2 * MAX_HALF_WINDOW + 1;
  localparam int SB   = $clog2(SPAN + 1);
  localparam int NW   = $clog2(SPAN * SPAN + 1);
  localparam int SW   = $clog2(255 * SPAN * SPAN + 1);
  localparam int DCW  = $clog2(SW);
  localparam int LW   = CW + 16;

  logic [23:0]   pix_mem [PIX_DEPTH];
  logic [HB-1:0] cls_mem [CLS_DEPTH];

  logic [10:0]   width_reg;
  logic [15:0]   height_reg;
  logic [WW-1:0] weff;
  logic [15:0]   heff;
  logic [LW-1:0] delay;

  logic [CW-1:0] in_col;
  logic [15:0]   in_row;
  logic [LW-1:0] lin;
  logic [PA-1:0] pix_wp;
  logic [CA-1:0] cls_wp;
  logic [CW-1:0] o_col;
  logic [15:0]   o_row;
  logic [PA-1:0] o_pix;
  logic [CA-1:0] o_cls;
  logic          draining;

  logic [23:0]   pix_q;
  logic [HB-1:0] cls_q;
  logic [HB-1:0] cls_in;
  logic [3:0]    half_raw;

  logic [HB-1:0] dr_up;
  logic [HB-1:0] dc_left;
  logic [SB-1:0] nrows;
  logic [SB-1:0] ncols;
  logic [HB-1:0] up_c;
  logic [HB-1:0] dn_c;
  logic [HB-1:0] lf_c;
  logic [HB-1:0] rt_c;
  logic [PA-1:0] offset;
  logic [NW-1:0] n_reg;
  logic [PA-1:0] rd_addr;
  logic [PA-1:0] row_start;
  logic [PA-1:0] start_addr;
  logic [PA:0]   addr_inc;
  logic [PA:0]   row_inc;
  logic [SB-1:0] rcnt;
  logic [SB-1:0] ccnt;
  logic          acc_en;
  logic [SW-1:0] sum_b;
  logic [SW-1:0] sum_g;
  logic [SW-1:0] sum_r;
  logic [SW-1:0] quo_b;
  logic [SW-1:0] quo_g;
  logic [SW-1:0] quo_r;
  logic [NW-1:0] rem_b;
  logic [NW-1:0] rem_g;
  logic [NW-1:0] rem_r;
  logic [DCW-1:0] dcnt;

  logic in_last;
  logic out_last;
  logic cfg_hit;
  logic pix_write;

  function automatic logic [NW+SW-1:0] div_step(input logic [NW-1:0] r,
                                                input logic [SW-1:0] q,
                                                input logic [NW-1:0] d);
    logic [NW:0] t;
    logic        b;
    t = {r, q[SW-1]};
    b = (t >= {1'b0, d});
    if (b) t = t - {1'b0, d};
    return {t[NW-1:0], q[SW-2:0], b};
  endfunction

  always_comb begin
    if (width_reg == 11'd0) weff = WW'(1);
    else if (32'(width_reg) > MAX_WIDTH) weff = WW'(MAX_WIDTH);
    else weff = WW'(width_reg);
    heff  = (height_reg == 16'd0) ? 16'd1 : height_reg;
    delay = LW'(MAX_HALF_WINDOW * (32'(weff) + 1));
  end

  assign half_raw = dabb_pkg::half_of(pixel.edge_distance);
  assign cls_in   = (32'(half_raw) > MAX_HALF_WINDOW) ? HB'(MAX_HALF_WINDOW)
                                                      : HB'(half_raw);

  assign in_last   = (WW'(in_col) == weff - WW'(1)) && (in_row == heff - 16'd1);
  assign out_last  = (WW'(o_col) == weff - WW'(1)) && (o_row == heff - 16'd1);
  assign cfg_hit   = cmd.cfg_write && ((cfg_index == dabb_pkg::REG_WIDTH) ||
                                       (cfg_index == dabb_pkg::REG_HEIGHT));
  assign pix_write = cmd.accept && (pixel.operation == dabb_pkg::OP_PIXEL);

  always_comb begin
    up_c = (32'(o_row) >= 32'(cls_q)) ? cls_q : HB'(o_row);
    dn_c = (32'(o_row) + 32'(cls_q) < 32'(heff)) ? cls_q
                                                : HB'(32'(heff) - 1 - 32'(o_row));
    lf_c = (32'(o_col) >= 32'(cls_q)) ? cls_q : HB'(o_col);
    rt_c = (32'(o_col) + 32'(cls_q) < 32'(weff)) ? cls_q
                                                : HB'(32'(weff) - 1 - 32'(o_col));
    start_addr = (o_pix >= offset) ? o_pix - offset
                                   : PA'(32'(o_pix) + PIX_DEPTH - 32'(offset));
    addr_inc = {1'b0, rd_addr} + (PA + 1)'(1);
    if (32'(addr_inc) >= PIX_DEPTH) addr_inc = addr_inc - (PA + 1)'(PIX_DEPTH);
    row_inc = {1'b0, row_start} + (PA + 1)'(weff);
    if (32'(row_inc) >= PIX_DEPTH) row_inc = row_inc - (PA + 1)'(PIX_DEPTH);
  end

  assign sts.do_emit  = (pixel.operation == dabb_pkg::OP_DRAIN) ? draining : (lin >= delay);
  assign sts.last_rd  = (ccnt == ncols - SB'(1)) && (rcnt == nrows - SB'(1));
  assign sts.div_done = (dcnt == DCW'(SW - 1));
  assign sts.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (pix_write) begin
      pix_mem[pix_wp] <= {pixel.red_in, pixel.green_in, pixel.blue_in};
      cls_mem[cls_wp] <= cls_in;
    end
    pix_q <= pix_mem[rd_addr];
    cls_q <= cls_mem[o_cls];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg    <= dabb_pkg::WIDTH_RESET;
      height_reg   <= dabb_pkg::HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      lin          <= '0;
      pix_wp       <= '0;
      cls_wp       <= '0;
      o_col        <= '0;
      o_row        <= '0;
      o_pix        <= '0;
      o_cls        <= '0;
      draining     <= 1'b0;
      result_valid <= 1'b0;
      acc_en       <= 1'b0;
    end else begin
      acc_en <= cmd.issue;
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (cmd.cfg_write) begin
        unique case (cfg_index)
          dabb_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
          dabb_pkg::REG_HEIGHT: height_reg <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        in_col   <= '0;
        in_row   <= '0;
        lin      <= '0;
        pix_wp   <= '0;
        cls_wp   <= '0;
        o_col    <= '0;
        o_row    <= '0;
        o_pix    <= '0;
        o_cls    <= '0;
        draining <= 1'b0;
      end
      if (pix_write) begin
        if (draining) begin
          o_col <= '0;
          o_row <= '0;
          o_pix <= '0;
          o_cls <= '0;
        end
        if (in_last) begin
          in_col   <= '0;
          in_row   <= '0;
          lin      <= '0;
          pix_wp   <= '0;
          cls_wp   <= '0;
          draining <= 1'b1;
        end else begin
          if (WW'(in_col) == weff - WW'(1)) begin
            in_col <= '0;
            in_row <= in_row + 16'd1;
          end else begin
            in_col <= in_col + CW'(1);
          end
          lin    <= lin + LW'(1);
          pix_wp <= (pix_wp == PA'(PIX_DEPTH - 1)) ? '0 : pix_wp + PA'(1);
          cls_wp <= (cls_wp == CA'(CLS_DEPTH - 1)) ? '0 : cls_wp + CA'(1);
          draining <= 1'b0;
        end
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
        if (out_last) begin
          o_col    <= '0;
          o_row    <= '0;
          o_pix    <= '0;
          o_cls    <= '0;
          draining <= 1'b0;
        end else begin
          if (WW'(o_col) == weff - WW'(1)) begin
            o_col <= '0;
            o_row <= o_row + 16'd1;
          end else begin
            o_col <= o_col + CW'(1);
          end
          o_pix <= (o_pix == PA'(PIX_DEPTH - 1)) ? '0 : o_pix + PA'(1);
          o_cls <= (o_cls == CA'(CLS_DEPTH - 1)) ? '0 : o_cls + CA'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      dr_up   <= up_c;
      dc_left <= lf_c;
      nrows   <= SB'(up_c) + SB'(dn_c) + SB'(1);
      ncols   <= SB'(lf_c) + SB'(rt_c) + SB'(1);
    end
    if (cmd.offset) begin
      offset <= PA'(32'(dr_up) * 32'(weff) + 32'(dc_left));
      n_reg  <= NW'(32'(nrows) * 32'(ncols));
    end
    if (cmd.start) begin
      row_start <= start_addr;
      rd_addr   <= start_addr;
      rcnt      <= '0;
      ccnt      <= '0;
      sum_b     <= '0;
      sum_g     <= '0;
      sum_r     <= '0;
    end
    if (cmd.issue) begin
      if (ccnt == ncols - SB'(1)) begin
        ccnt      <= '0;
        rcnt      <= rcnt + SB'(1);
        row_start <= row_inc[PA-1:0];
        rd_addr   <= row_inc[PA-1:0];
      end else begin
        ccnt    <= ccnt + SB'(1);
        rd_addr <= addr_inc[PA-1:0];
      end
    end
    if (acc_en) begin
      sum_b <= sum_b + SW'(pix_q[7:0]);
      sum_g <= sum_g + SW'(pix_q[15:8]);
      sum_r <= sum_r + SW'(pix_q[23:16]);
    end
    if (cmd.div_init) begin
      quo_b <= sum_b;
      quo_g <= sum_g;
      quo_r <= sum_r;
      rem_b <= '0;
      rem_g <= '0;
      rem_r <= '0;
      dcnt  <= '0;
    end
    if (cmd.div_step) begin
      {rem_b, quo_b} <= div_step(rem_b, quo_b, n_reg);
      {rem_g, quo_g} <= div_step(rem_g, quo_g, n_reg);
      {rem_r, quo_r} <= div_step(rem_r, quo_r, n_reg);
      dcnt <= dcnt + DCW'(1);
    end
    if (cmd.load) begin
      result.blue_out  <= quo_b[7:0];
      result.green_out <= quo_g[7:0];
      result.red_out   <= quo_r[7:0];
      result.frame_end <= out_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/distance_adaptive_box_blur_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Spatially varying box blur over a raster pixel stream. Each pixel word carries an
// edge distance that selects a square window (pass-through, 3x3, 5x5, 7x7 or 9x9),
// and each color channel of the result is the truncated mean over that window,
// clipped at the image borders. A result leaves MAX_HALF_WINDOW rows plus
// MAX_HALF_WINDOW pixels behind its input; drain words release the tail of a frame.
// Words are handled one at a time. For a word that produces a result, the core then
// computes the clipped window bounds and its line-store offset, reads each pixel of
// that window (one line-store read per cycle), divides the channel sums with a
// bit-serial divider whose dividend is 15 bits wide for the default window limit,
// and waits for the previous result word to be taken.
// Writing image_width or image_height restarts the frame.
module distance_adaptive_box_blur_core #(
  parameter int MAX_WIDTH       = dabb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF_WINDOW = dabb_pkg::MAX_HALF_WINDOW_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pixel_valid,
  output logic                     pixel_stall,
  input  wire dabb_pkg::in_word_t  pixel,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output dabb_pkg::out_word_t      result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  dabb_pkg::cmd_t cmd;
  dabb_pkg::sts_t sts;

  dabb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  dabb_datapath #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .pixel        (pixel),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
